// ===== rtl/version_vector_compare_merge_assert.svh =====
// Assertion macros for the version vector compare/merge block.
// Used by the top level; no other dependencies.
`ifndef VERSION_VECTOR_COMPARE_MERGE_ASSERT_SVH
`define VERSION_VECTOR_COMPARE_MERGE_ASSERT_SVH
`ifndef SYNTH
`define VVCM_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("vvcm assertion failed");
`define VVCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vvcm assertion failed");
`else
`define VVCM_ASSERT(lbl, clk, rst_n, cond)
`define VVCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/vvcm_pkg.sv =====
// Shared types, constants and the relation fold for the version vector block.
// No dependencies.
`default_nettype none
package vvcm_pkg;

	localparam int NUM_CELLS = 16;
	localparam int KEY_W     = 32;
	localparam int CNT_W     = 64;

	localparam logic [1:0] KIND_CMP   = 2'd0;
	localparam logic [1:0] KIND_MERGE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] REL_EQ  = 2'd0;
	localparam logic [1:0] REL_LT  = 2'd1;
	localparam logic [1:0] REL_GT  = 2'd2;
	localparam logic [1:0] REL_NEQ = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	// request captured at accept
	typedef struct packed {
		logic [1:0]       kind;
		logic             present;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} req_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic             look;
		logic             upd;
		logic [1:0]       kind;
		logic             present;
		logic             last;
		logic             found;
		logic             raise;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
	} ctl_t;

	// passed from cell to cell
	typedef struct packed {
		logic [CNT_W-1:0] local_cnt;
		logic             hit_any;
		logic             free_seen;
		logic             unmatched_nz;
	} chain_t;

	function automatic logic [1:0] rel_fold(input logic [1:0] cur, input logic [1:0] cmp);
		logic [1:0] res;
		if (cur == REL_NEQ) begin
			res = REL_NEQ;
		end else if (cur == REL_EQ) begin
			res = cmp;
		end else if (cmp == REL_EQ || cmp == cur) begin
			res = cur;
		end else begin
			res = REL_NEQ;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vvcm_req_if.sv =====
// Request channel: valid/ready with one entry of the other vector.
// Depends on vvcm_pkg.
`default_nettype none
interface vvcm_req_if;
	import vvcm_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic             entry_present;
	logic [KEY_W-1:0] entry_key;
	logic [CNT_W-1:0] entry_counter;
	logic             last_entry;

	modport source (
		output valid, kind, entry_present, entry_key, entry_counter, last_entry,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_present, entry_key, entry_counter, last_entry,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/vvcm_rsp_if.sv =====
// Response channel: valid/ready with the per-request result.
// Depends on vvcm_pkg.
`default_nettype none
interface vvcm_rsp_if;
	import vvcm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] local_counter;
	logic             order_ready;
	logic [1:0]       order_result;
	logic             table_full;

	modport source (
		output valid, local_counter, order_ready, order_result, table_full,
		input  ready
	);
	modport sink (
		input  valid, local_counter, order_ready, order_result, table_full,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/vvcm_cell.sv =====
// One slot of the local version vector: key, counter, used and matched flags.
// Depends on vvcm_pkg; chained by the top level.
`default_nettype none
module vvcm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  vvcm_pkg::ctl_t   ctl,
	input  vvcm_pkg::chain_t prev,
	output vvcm_pkg::chain_t next
);
	import vvcm_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	logic             used_q;
	logic             mark_q;
	logic             hit_q;

	logic hit;
	logic take_free;
	logic end_cmp;
	logic eff_mark;
	logic append;

	assign hit       = used_q && (key_q == ctl.key);
	assign take_free = !used_q && !prev.free_seen;
	assign end_cmp   = ctl.last || !ctl.present;
	assign eff_mark  = mark_q || (hit_q && ctl.present);
	assign append    = ctl.present && !ctl.found && take_free;

	assign next.local_cnt    = prev.local_cnt | (hit ? cnt_q : '0);
	assign next.hit_any      = prev.hit_any | hit;
	assign next.free_seen    = prev.free_seen | !used_q;
	assign next.unmatched_nz = prev.unmatched_nz | (used_q && !eff_mark && (cnt_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			mark_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (ctl.look) begin
				hit_q <= hit;
			end
			if (ctl.upd) begin
				case (ctl.kind)
					KIND_CMP: begin
						if (end_cmp) begin
							mark_q <= 1'b0;
						end else if (hit_q) begin
							mark_q <= 1'b1;
						end
					end
					KIND_MERGE: begin
						if (append) begin
							used_q <= 1'b1;
							mark_q <= 1'b0;
						end
					end
					KIND_CLEAR: begin
						used_q <= 1'b0;
						mark_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload: raise a matched counter or take a new entry
	always_ff @(posedge clk) begin
		if (ctl.upd && ctl.kind == KIND_MERGE && ctl.present) begin
			if (hit_q && ctl.raise) begin
				cnt_q <= ctl.cnt;
			end else if (append) begin
				key_q <= ctl.key;
				cnt_q <= ctl.cnt;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/version_vector_compare_merge.sv =====
// Top level of the version vector compare/merge block: sequencer, cell chain,
// result register. Depends on vvcm_pkg, vvcm_req_if, vvcm_rsp_if, vvcm_cell.
`default_nettype none
//
//  chan | dir | payload
//  -----+-----+--------------------------------------------------------------
//  req  | in  | kind, entry_present, entry_key, entry_counter, last_entry
//  rsp  | out | local_counter, order_ready, order_result, table_full
//
//  Each request passes a lookup step, which matches its key in every cell, then an
//  update step, which folds the order and updates the cells; the cell chain does the
//  key match, counter select, first-free and unmatched scans.
//  Reset clears the used/matched flags, the running relation and the sequencer.
//  A stalled rsp holds the block in the update step; the next request is taken
//  in the same cycle that the result moves into the result register.
//
module version_vector_compare_merge (
	input  logic        clk,
	input  logic        arst_n,
	vvcm_req_if.sink    req,
	vvcm_rsp_if.source  rsp
);
	import vvcm_pkg::*;

	state_t state_q;
	state_t state_d;

	req_t       req_q;
	logic [1:0] order_q;

	// captured at the end of the lookup step
	logic [CNT_W-1:0] local_q;
	logic             found_q;

	// result register
	logic             rsp_valid_q;
	logic [CNT_W-1:0] rsp_local_q;
	logic             rsp_ordrdy_q;
	logic [1:0]       rsp_result_q;
	logic             rsp_full_q;

	logic   accept;
	logic   out_free;
	logic   look;
	logic   upd_fire;
	ctl_t   ctl;
	chain_t chain [NUM_CELLS+1];

	logic       end_cmp;
	logic       is_cmp;
	logic [1:0] pair_rel;
	logic [1:0] fold1;
	logic [1:0] fold2;
	logic       full;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		look      = 1'b0;
		upd_fire  = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				look    = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				// drain into the result register, take the next request alongside
				if (out_free) begin
					upd_fire  = 1'b1;
					req.ready = 1'b1;
					state_d   = req.valid ? ST_LOOKUP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the request for its two steps
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.kind    <= req.kind;
			req_q.present <= req.entry_present;
			req_q.key     <= req.entry_key;
			req_q.cnt     <= req.entry_counter;
			req_q.last    <= req.last_entry;
		end
		if (look) begin
			local_q <= chain[NUM_CELLS].local_cnt;
			found_q <= chain[NUM_CELLS].hit_any;
		end
	end

	// pair order of local against other; one wide compare serves both the
	// fold and the merge raise
	always_comb begin
		if (local_q == req_q.cnt) begin
			pair_rel = REL_EQ;
		end else if (local_q < req_q.cnt) begin
			pair_rel = REL_LT;
		end else begin
			pair_rel = REL_GT;
		end
	end

	assign ctl.look    = look;
	assign ctl.upd     = upd_fire;
	assign ctl.kind    = req_q.kind;
	assign ctl.present = req_q.present;
	assign ctl.last    = req_q.last;
	assign ctl.found   = found_q;
	assign ctl.raise   = (pair_rel == REL_LT);
	assign ctl.key     = req_q.key;
	assign ctl.cnt     = req_q.cnt;

	// cell chain; the head sees an empty vector
	assign chain[0] = '0;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		vvcm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   (chain[g]),
			.next   (chain[g+1])
		);
	end

	// fold this pair, then the unmatched local entries on the last request
	assign is_cmp  = (req_q.kind == KIND_CMP);
	assign end_cmp = is_cmp && (req_q.last || !req_q.present);
	assign fold1   = req_q.present ? rel_fold(order_q, pair_rel) : order_q;
	assign fold2   = chain[NUM_CELLS].unmatched_nz ? rel_fold(fold1, REL_GT) : fold1;
	assign full    = (req_q.kind == KIND_MERGE) && req_q.present && !found_q &&
		!chain[NUM_CELLS].free_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= REL_EQ;
			rsp_valid_q <= 1'b0;
		end else begin
			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
				if (req_q.kind == KIND_CLEAR || end_cmp) begin
					order_q <= REL_EQ;
				end else if (is_cmp) begin
					order_q <= fold1;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			rsp_local_q  <= local_q;
			rsp_ordrdy_q <= end_cmp;
			rsp_result_q <= end_cmp ? fold2 : REL_EQ;
			rsp_full_q   <= full;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.local_counter = rsp_local_q;
	assign rsp.order_ready   = rsp_ordrdy_q;
	assign rsp.order_result  = rsp_result_q;
	assign rsp.table_full    = rsp_full_q;

`include "version_vector_compare_merge_assert.svh"

	// an accepted request always goes to the lookup step next
	`VVCM_ASSERT_NEXT(a_accept_lookup, clk, arst_n, accept, state_q == ST_LOOKUP)
	// a blocked result register holds the update step
	`VVCM_ASSERT_NEXT(a_stall_hold, clk, arst_n, state_q == ST_UPDATE && !out_free,
		state_q == ST_UPDATE)
	// a final comparison restarts the running relation
	`VVCM_ASSERT_NEXT(a_order_restart, clk, arst_n, upd_fire && end_cmp, order_q == REL_EQ)
	// no request is taken during the lookup step
	`VVCM_ASSERT(a_no_accept_lookup, clk, arst_n, state_q != ST_LOOKUP || !req.ready)

endmodule
`default_nettype wire
